[src/sgrs_pkg.sv]
// ----------------------------------------------------------------------------
// sgrs_pkg
// types and constants shared by the scatter-gather rdma segmenter
// ----------------------------------------------------------------------------
package sgrs_pkg;

    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned CNT_W       = 6;

    typedef enum logic [1:0] {
        REQ_LOAD_LOCAL  = 2'd0,
        REQ_LOAD_REMOTE = 2'd1,
        REQ_START       = 2'd2,
        REQ_NONE        = 2'd3
    } req_type_t;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_STATUS  = 1'b1
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RCAP_INIT,
        ST_CHECK_L,
        ST_LCAP,
        ST_STEP,
        ST_RCAP
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] seg_addr;
        logic [30:0] seg_len;
        logic [3:0]  seg_index;
        logic [4:0]  local_start;
        logic [4:0]  remote_start;
        logic [4:0]  local_count;
        logic [4:0]  remote_count;
        logic        is_read;
    } req_t;

    typedef struct packed {
        logic        res_kind;
        logic [63:0] local_addr;
        logic [4:0]  local_index;
        logic [63:0] remote_addr;
        logic [4:0]  remote_index;
        logic [30:0] length;
        logic [30:0] local_remain;
        logic [30:0] remote_remain;
        logic        signalled;
        logic        remote_reload;
        logic        local_complete;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [30:0] len;
    } seg_t;

endpackage

[src/scatter_gather_rdma_segmenter_core.sv]
// walk: a start reads the first remote segment, if any, then each local segment in turn before
// its requests; empty local segments are skipped, and a status ends the walk
// throughput: one request per cycle while the result slot is free; reading the next local or
// remote segment holds the stream of requests
// load transactions are accepted only while idle and give no result; a waiting result holds the walk
// reset: control state and the result valid are cleared; the memories hold undefined data
// ----------------------------------------------------------------------------
// scatter_gather_rdma_segmenter_core
// walks a local and a remote scatter-gather list held in two memories and
// emits one rdma request per overlap, then a final status
// ----------------------------------------------------------------------------
module scatter_gather_rdma_segmenter_core #(
    parameter int unsigned MAX_SEGS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sgrs_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_ready,
    output sgrs_pkg::res_t  res
);

    localparam int unsigned IW  = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int unsigned CW  = $clog2(MAX_SEGS + 1);
    localparam int unsigned IXW = (CW > 5) ? CW : 5;
    localparam logic [IXW-1:0] SEGS = IXW'(MAX_SEGS);

    // segment memories, one read port each with registered data
    sgrs_pkg::seg_t local_mem  [MAX_SEGS];
    sgrs_pkg::seg_t remote_mem [MAX_SEGS];
    sgrs_pkg::seg_t l_rd_data;
    sgrs_pkg::seg_t r_rd_data;

    logic           l_rd_en;
    logic [IW-1:0]  l_rd_addr;
    logic           r_rd_en;
    logic [IW-1:0]  r_rd_addr;
    logic           l_wr_en;
    logic           r_wr_en;
    logic [IW-1:0]  wr_addr;
    sgrs_pkg::seg_t wr_data;

    sgrs_pkg::state_t state_reg, state_next;
    logic [IXW-1:0]   i_reg, i_next;
    logic [IXW-1:0]   r_reg, r_next;
    logic [IXW-1:0]   lc_reg, lc_next;
    logic [IXW-1:0]   rc_reg, rc_next;
    logic [63:0]      saddr_reg, saddr_next;
    logic [30:0]      slen_reg, slen_next;
    logic [63:0]      raddr_reg, raddr_next;
    logic [30:0]      rlen_reg, rlen_next;
    logic             stop_reg, stop_next;
    logic [sgrs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    sgrs_pkg::res_t   res_reg, res_next;

    logic             accept;
    logic             slot_free;
    logic             emit;
    sgrs_pkg::res_t   emit_data;
    logic [IXW-1:0]   ls_ext, rs_ext, lc_ext, rc_ext, lc_clamp, rc_clamp;
    logic [30:0]      len;
    logic [30:0]      slen_left;
    logic [IXW-1:0]   r_inc;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == sgrs_pkg::ST_IDLE);
    assign slot_free = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign ls_ext   = IXW'(req.local_start);
    assign rs_ext   = IXW'(req.remote_start);
    assign lc_ext   = IXW'(req.local_count);
    assign rc_ext   = IXW'(req.remote_count);
    assign lc_clamp = (lc_ext > SEGS) ? SEGS : lc_ext;
    assign rc_clamp = (rc_ext > SEGS) ? SEGS : rc_ext;

    assign len       = (slen_reg < rlen_reg) ? slen_reg : rlen_reg;
    assign slen_left = slen_reg - len;
    assign r_inc     = r_reg + IXW'(1);

    // load transactions
    assign wr_addr = IW'(req.seg_index);
    assign wr_data = '{addr: req.seg_addr, len: req.seg_len};
    assign l_wr_en = accept && (req.req_type == sgrs_pkg::REQ_LOAD_LOCAL)
                     && ({1'b0, req.seg_index} < 5'(MAX_SEGS > 31 ? 31 : MAX_SEGS)
                         || MAX_SEGS > 16);
    assign r_wr_en = accept && (req.req_type == sgrs_pkg::REQ_LOAD_REMOTE)
                     && ({1'b0, req.seg_index} < 5'(MAX_SEGS > 31 ? 31 : MAX_SEGS)
                         || MAX_SEGS > 16);

    always_ff @(posedge clk)
    begin
        if (l_wr_en)
        begin
            local_mem[wr_addr] <= wr_data;
        end
        if (l_rd_en)
        begin
            l_rd_data <= local_mem[l_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_wr_en)
        begin
            remote_mem[wr_addr] <= wr_data;
        end
        if (r_rd_en)
        begin
            r_rd_data <= remote_mem[r_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgrs_pkg::ST_IDLE;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        r_reg     <= r_next;
        lc_reg    <= lc_next;
        rc_reg    <= rc_next;
        saddr_reg <= saddr_next;
        slen_reg  <= slen_next;
        raddr_reg <= raddr_next;
        rlen_reg  <= rlen_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        r_next     = r_reg;
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        saddr_next = saddr_reg;
        slen_next  = slen_reg;
        raddr_next = raddr_reg;
        rlen_next  = rlen_reg;
        stop_next  = stop_reg;
        l_rd_en    = 1'b0;
        l_rd_addr  = i_reg[IW-1:0];
        r_rd_en    = 1'b0;
        r_rd_addr  = r_reg[IW-1:0];
        emit       = 1'b0;
        emit_data  = '0;

        unique case (state_reg)
            sgrs_pkg::ST_IDLE:
            begin
                if (accept && req.req_type == sgrs_pkg::REQ_START)
                begin
                    i_next    = ls_ext;
                    lc_next   = lc_clamp;
                    rc_next   = rc_clamp;
                    stop_next = 1'b0;
                    if (rs_ext < rc_clamp)
                    begin
                        r_next     = rs_ext;
                        r_rd_en    = 1'b1;
                        r_rd_addr  = rs_ext[IW-1:0];
                        state_next = sgrs_pkg::ST_RCAP_INIT;
                    end
                    else
                    begin
                        r_next     = rc_clamp;
                        raddr_next = '0;
                        rlen_next  = '0;
                        state_next = sgrs_pkg::ST_CHECK_L;
                    end
                end
            end

            sgrs_pkg::ST_RCAP_INIT:
            begin
                raddr_next = r_rd_data.addr;
                rlen_next  = r_rd_data.len;
                state_next = sgrs_pkg::ST_CHECK_L;
            end

            sgrs_pkg::ST_CHECK_L:
            begin
                if (i_reg < lc_reg)
                begin
                    l_rd_en    = 1'b1;
                    state_next = sgrs_pkg::ST_LCAP;
                end
                else if (slot_free)
                begin
                    // completion status
                    emit                     = 1'b1;
                    emit_data.res_kind       = sgrs_pkg::KIND_STATUS;
                    emit_data.local_index    = i_reg[4:0];
                    emit_data.remote_addr    = raddr_reg;
                    emit_data.remote_index   = r_reg[4:0];
                    emit_data.remote_remain  = rlen_reg;
                    emit_data.remote_reload  = (r_reg >= rc_reg);
                    emit_data.local_complete = 1'b1;
                    emit_data.last           = 1'b1;
                    state_next               = sgrs_pkg::ST_IDLE;
                end
            end

            sgrs_pkg::ST_LCAP:
            begin
                saddr_next = l_rd_data.addr;
                slen_next  = l_rd_data.len;
                state_next = sgrs_pkg::ST_STEP;
            end

            sgrs_pkg::ST_STEP:
            begin
                if (!stop_reg && slen_reg == '0)
                begin
                    // empty or finished local segment
                    i_next     = i_reg + IXW'(1);
                    state_next = sgrs_pkg::ST_CHECK_L;
                end
                else if (stop_reg || r_reg >= rc_reg)
                begin
                    if (slot_free)
                    begin
                        // reload status: remote list used up
                        emit                    = 1'b1;
                        emit_data.res_kind      = sgrs_pkg::KIND_STATUS;
                        emit_data.local_addr    = saddr_reg;
                        emit_data.local_index   = i_reg[4:0];
                        emit_data.remote_index  = rc_reg[4:0];
                        emit_data.local_remain  = slen_reg;
                        emit_data.remote_reload = 1'b1;
                        emit_data.last          = 1'b1;
                        state_next              = sgrs_pkg::ST_IDLE;
                    end
                end
                else if (slot_free)
                begin
                    emit                   = 1'b1;
                    emit_data.res_kind     = sgrs_pkg::KIND_REQUEST;
                    emit_data.local_addr   = saddr_reg;
                    emit_data.local_index  = i_reg[4:0];
                    emit_data.remote_addr  = raddr_reg;
                    emit_data.remote_index = r_reg[4:0];
                    emit_data.length       = len;
                    emit_data.signalled    = ((i_reg + IXW'(1) == lc_reg) && slen_reg == len)
                                             || ((r_inc == rc_reg) && rlen_reg == len);
                    saddr_next = saddr_reg + 64'(len);
                    slen_next  = slen_left;
                    if (len < rlen_reg)
                    begin
                        raddr_next = raddr_reg + 64'(len);
                        rlen_next  = rlen_reg - len;
                        if (slen_left == '0)
                        begin
                            i_next     = i_reg + IXW'(1);
                            state_next = sgrs_pkg::ST_CHECK_L;
                        end
                    end
                    else
                    begin
                        r_next = r_inc;
                        if (r_inc < rc_reg)
                        begin
                            r_rd_en    = 1'b1;
                            r_rd_addr  = r_inc[IW-1:0];
                            state_next = sgrs_pkg::ST_RCAP;
                        end
                        else
                        begin
                            raddr_next = '0;
                            rlen_next  = '0;
                            if (slen_left == '0)
                            begin
                                // stop at the start of the next local segment
                                stop_next  = (i_reg + IXW'(1) != lc_reg);
                                i_next     = i_reg + IXW'(1);
                                state_next = sgrs_pkg::ST_CHECK_L;
                            end
                        end
                    end
                end
            end

            sgrs_pkg::ST_RCAP:
            begin
                raddr_next = r_rd_data.addr;
                rlen_next  = r_rd_data.len;
                state_next = sgrs_pkg::ST_STEP;
            end

            default:
            begin
                state_next = sgrs_pkg::ST_IDLE;
            end
        endcase
    end

    // output register, results past the limit are dropped
    always_comb
    begin
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (accept && req.req_type == sgrs_pkg::REQ_START)
        begin
            cnt_next = '0;
        end
        else if (emit && cnt_reg < sgrs_pkg::CNT_W'(sgrs_pkg::MAX_RESULTS))
        begin
            cnt_next       = cnt_reg + sgrs_pkg::CNT_W'(1);
            res_next       = emit_data;
            res_valid_next = 1'b1;
        end
    end

endmodule

[test/sgrs_scoreboard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgrs_scoreboard
// watches both channels of the segmenter, mirrors the two segment lists,
// splits every walk into its expected rdma pieces and final status and
// compares each result transaction field by field against the oldest one
// ----------------------------------------------------------------------------
module sgrs_scoreboard (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  sgrs_pkg::req_t   req,
    input  logic             res_valid,
    input  logic             res_ready,
    input  sgrs_pkg::res_t   res,
    output int unsigned      mismatch_count,
    output int unsigned      outstanding
);

    localparam int SEGS = 16;

    logic [63:0] loc_seg_addr [SEGS];
    logic [30:0] loc_seg_len  [SEGS];
    logic [63:0] rem_seg_addr [SEGS];
    logic [30:0] rem_seg_len  [SEGS];

    sgrs_pkg::res_t expected_pieces_q[$];
    sgrs_pkg::res_t oldest;
    int unsigned    errs = 0;

    initial
    begin
        for (int k = 0; k < SEGS; k++)
        begin
            loc_seg_addr[k] = '0;
            loc_seg_len[k]  = '0;
            rem_seg_addr[k] = '0;
            rem_seg_len[k]  = '0;
        end
    end

    function automatic sgrs_pkg::res_t make_result(
        input sgrs_pkg::res_kind_t kind,
        input logic [63:0] la,
        input int          li,
        input logic [63:0] ra,
        input int          ri,
        input logic [30:0] len,
        input logic [30:0] lrem,
        input logic [30:0] rrem,
        input logic        sig,
        input logic        reload,
        input logic        complete,
        input logic        fin
    );
        sgrs_pkg::res_t p;
        p.res_kind       = kind;
        p.local_addr     = la;
        p.local_index    = 5'(li);
        p.remote_addr    = ra;
        p.remote_index   = 5'(ri);
        p.length         = len;
        p.local_remain   = lrem;
        p.remote_remain  = rrem;
        p.signalled      = sig;
        p.remote_reload  = reload;
        p.local_complete = complete;
        p.last           = fin;
        return p;
    endfunction

    // walk both lists and queue one piece per overlap, then the status
    task automatic split_overlaps(input sgrs_pkg::req_t item);
        int             ls, rs, lc, rc, i, ri;
        logic [63:0]    saddr, raddr;
        logic [30:0]    slen, rlen, len;
        logic           sig;
        bit             done;
        sgrs_pkg::res_t walk_q[$];

        ls = int'(item.local_start);
        rs = int'(item.remote_start);
        lc = int'(item.local_count);
        rc = int'(item.remote_count);
        if (lc > SEGS) lc = SEGS;
        if (rc > SEGS) rc = SEGS;

        ri = rs;
        if (ri < rc)
        begin
            raddr = rem_seg_addr[ri];
            rlen  = rem_seg_len[ri];
        end
        else
        begin
            ri    = rc;
            raddr = '0;
            rlen  = '0;
        end

        done = 0;
        for (i = ls; i < lc && !done; i++)
        begin
            saddr = loc_seg_addr[i];
            slen  = loc_seg_len[i];
            while (slen != 0 && !done)
            begin
                if (ri >= rc)
                begin
                    walk_q.push_back(make_result(sgrs_pkg::KIND_STATUS, saddr, i, '0, rc,
                                                 '0, slen, '0, 1'b0, 1'b1, 1'b0, 1'b1));
                    done = 1;
                end
                else
                begin
                    len = (slen < rlen) ? slen : rlen;
                    sig = (i == lc - 1 && slen == len) || (ri == rc - 1 && rlen == len);
                    walk_q.push_back(make_result(sgrs_pkg::KIND_REQUEST, saddr, i, raddr,
                                                 ri, len, '0, '0, sig, 1'b0, 1'b0, 1'b0));
                    if (len < rlen)
                    begin
                        raddr += 64'(len);
                        rlen  -= len;
                    end
                    else
                    begin
                        ri++;
                        if (ri < rc)
                        begin
                            raddr = rem_seg_addr[ri];
                            rlen  = rem_seg_len[ri];
                        end
                        else
                        begin
                            raddr = '0;
                            rlen  = '0;
                        end
                    end
                    saddr += 64'(len);
                    slen  -= len;
                    // remote list gone while local data is left: stop and ask for reload
                    if (ri == rc && (i != lc - 1 || slen != 0))
                    begin
                        if (slen != 0)
                            walk_q.push_back(make_result(sgrs_pkg::KIND_STATUS, saddr, i,
                                                         '0, rc, '0, slen, '0,
                                                         1'b0, 1'b1, 1'b0, 1'b1));
                        else
                            walk_q.push_back(make_result(sgrs_pkg::KIND_STATUS,
                                                         loc_seg_addr[i + 1], i + 1,
                                                         '0, rc, '0, loc_seg_len[i + 1],
                                                         '0, 1'b0, 1'b1, 1'b0, 1'b1));
                        done = 1;
                    end
                end
            end
        end

        if (!done)
            walk_q.push_back(make_result(sgrs_pkg::KIND_STATUS, '0, (ls > lc) ? ls : lc,
                                         raddr, ri, '0, '0, rlen, 1'b0,
                                         logic'(ri >= rc), 1'b1, 1'b1));

        foreach (walk_q[k])
            if (k < sgrs_pkg::MAX_RESULTS)
                expected_pieces_q.push_back(walk_q[k]);
    endtask

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                case (sgrs_pkg::req_type_t'(req.req_type))
                    sgrs_pkg::REQ_LOAD_LOCAL:
                    begin
                        loc_seg_addr[req.seg_index] = req.seg_addr;
                        loc_seg_len[req.seg_index]  = req.seg_len;
                    end
                    sgrs_pkg::REQ_LOAD_REMOTE:
                    begin
                        rem_seg_addr[req.seg_index] = req.seg_addr;
                        rem_seg_len[req.seg_index]  = req.seg_len;
                    end
                    sgrs_pkg::REQ_START:
                        split_overlaps(req);
                    default:
                        ;
                endcase
            end

            if (res_valid && res_ready)
            begin
                if (expected_pieces_q.size() == 0)
                begin
                    $display("%0t: result expected none actual %h", $time, res);
                    errs++;
                end
                else
                begin
                    oldest = expected_pieces_q.pop_front();
                    check_field("res_kind", 64'(oldest.res_kind), 64'(res.res_kind));
                    check_field("local_addr", oldest.local_addr, res.local_addr);
                    check_field("local_index", 64'(oldest.local_index),
                                64'(res.local_index));
                    check_field("remote_addr", oldest.remote_addr, res.remote_addr);
                    check_field("remote_index", 64'(oldest.remote_index),
                                64'(res.remote_index));
                    check_field("length", 64'(oldest.length), 64'(res.length));
                    check_field("local_remain", 64'(oldest.local_remain),
                                64'(res.local_remain));
                    check_field("remote_remain", 64'(oldest.remote_remain),
                                64'(res.remote_remain));
                    check_field("signalled", 64'(oldest.signalled), 64'(res.signalled));
                    check_field("remote_reload", 64'(oldest.remote_reload),
                                64'(res.remote_reload));
                    check_field("local_complete", 64'(oldest.local_complete),
                                64'(res.local_complete));
                    check_field("last", 64'(oldest.last), 64'(res.last));
                end
            end
        end
        mismatch_count <= errs;
        outstanding    <= expected_pieces_q.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives segment loads and list walks into the segmenter with random
// idling on both channels and gives the verdict from the scoreboard
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned ITEM_TARGET  = 380;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int          SEGS         = 16;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    sgrs_pkg::req_t req;
    logic           res_valid;
    logic           res_ready = 1'b0;
    sgrs_pkg::res_t res;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned sent_items;
    int unsigned cycle_cnt;
    int unsigned sink_hold;
    bit          idle_on;
    bit          local_loaded  [SEGS];
    bit          remote_loaded [SEGS];

    scatter_gather_rdma_segmenter_core #(
        .MAX_SEGS (SEGS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sgrs_scoreboard i_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side stalls in bursts
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold--;
            res_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            sink_hold = $urandom_range(1, 16) - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    function automatic sgrs_pkg::req_t random_item();
        sgrs_pkg::req_t item;
        item.req_type     = sgrs_pkg::REQ_NONE;
        item.seg_addr     = {$urandom(), $urandom()};
        item.seg_len      = 31'($urandom());
        item.seg_index    = 4'($urandom());
        item.local_start  = 5'($urandom());
        item.remote_start = 5'($urandom());
        item.local_count  = 5'($urandom());
        item.remote_count = 5'($urandom());
        item.is_read      = 1'($urandom());
        return item;
    endfunction

    function automatic logic [30:0] random_len(input int cls);
        if ($urandom_range(0, 7) == 0)
            return '0;
        case (cls)
            0:       return 31'($urandom_range(0, 8));
            1:       return 31'($urandom_range(0, 500));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic send_item(input sgrs_pkg::req_t item);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (item.req_type != sgrs_pkg::REQ_NONE)
            sent_items++;
    endtask

    task automatic load_segment(input bit to_remote, input int idx,
                                input logic [63:0] addr, input logic [30:0] len);
        sgrs_pkg::req_t item;
        item           = random_item();
        item.req_type  = to_remote ? sgrs_pkg::REQ_LOAD_REMOTE : sgrs_pkg::REQ_LOAD_LOCAL;
        item.seg_index = 4'(idx);
        item.seg_addr  = addr;
        item.seg_len   = len;
        if (to_remote)
            remote_loaded[idx] = 1'b1;
        else
            local_loaded[idx] = 1'b1;
        send_item(item);
    endtask

    task automatic start_walk(input int ls, input int rs, input int lc, input int rc,
                              input bit rd);
        sgrs_pkg::req_t item;
        item              = random_item();
        item.req_type     = sgrs_pkg::REQ_START;
        item.local_start  = 5'(ls);
        item.remote_start = 5'(rs);
        item.local_count  = 5'(lc);
        item.remote_count = 5'(rc);
        item.is_read      = rd;
        send_item(item);
    endtask

    initial
    begin : stimulus
        int cls, ls, rs, lc, rc, lce, rce, extra, idx;
        bit pick_remote;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        idle_on    = 1'b1;
        sent_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed walks over a handful of hand-made segments
        load_segment(0, 0, 64'hFFFF_FFFF_FFFF_FFF0, 31'd16);
        load_segment(0, 1, 64'h0, 31'd0);
        load_segment(0, 2, 64'h0000_0000_0000_1000, 31'h7FFF_FFFF);
        load_segment(1, 0, 64'h0, 31'd10);
        load_segment(1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0);
        load_segment(1, 2, 64'h0000_0000_0000_5000, 31'h7FFF_FFFF);
        send_item(random_item());
        // zero-length segments on both sides, reload mid local segment
        start_walk(0, 0, 3, 3, 1);
        // write walk from a nonzero remote start, remote count clamped
        start_walk(0, 2, 1, 20, 0);
        // local start past local count
        start_walk(5, 0, 3, 3, 1);
        start_walk(31, 31, 31, 0, 0);
        // remote start past remote count
        start_walk(0, 4, 1, 3, 1);
        load_segment(1, 3, 64'h0000_0000_0000_8000, 31'd16);
        // remote list used up exactly at the end of the local list
        start_walk(0, 3, 1, 4, 0);
        // remote list used up exactly with local segments left
        start_walk(0, 3, 3, 4, 1);
        start_walk(0, 0, 0, 0, 0);
        load_segment(0, 15, {$urandom(), $urandom()}, 31'd1);
        load_segment(1, 15, {$urandom(), $urandom()}, 31'h7FFF_FFFF);
        start_walk(15, 15, 16, 16, 1);
        // local count clamped, remote ends first
        start_walk(2, 0, 20, 1, 1);

        while (sent_items < ITEM_TARGET)
        begin
            idle_on = (sent_items < 150 || sent_items >= 200) && sent_items + 60 < ITEM_TARGET;

            cls = $urandom_range(0, 9);
            cls = (cls < 5) ? 0 : (cls < 9) ? 1 : 2;
            lc  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            rc  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            lce = (lc > SEGS) ? SEGS : lc;
            rce = (rc > SEGS) ? SEGS : rc;
            ls  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, lce);
            rs  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, rce);

            // every entry the walk may read has to hold a segment
            for (int k = ls; k < lce; k++)
                if (!local_loaded[k])
                    load_segment(0, k, {$urandom(), $urandom()}, random_len(cls));
            for (int k = rs; k < rce; k++)
                if (!remote_loaded[k])
                    load_segment(1, k, {$urandom(), $urandom()}, random_len(cls));

            extra = $urandom_range(0, 4);
            repeat (extra)
            begin
                pick_remote = 1'($urandom());
                if (pick_remote && rs < rce)
                    idx = $urandom_range(rs, rce - 1);
                else if (!pick_remote && ls < lce)
                    idx = $urandom_range(ls, lce - 1);
                else
                    idx = $urandom_range(0, SEGS - 1);
                load_segment(pick_remote, idx, {$urandom(), $urandom()}, random_len(cls));
            end

            if ($urandom_range(0, 14) == 0)
                send_item(random_item());
            start_walk(ls, rs, lc, rc, 1'($urandom()));
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
src/sgrs_pkg.sv
src/scatter_gather_rdma_segmenter_core.sv
test/sgrs_scoreboard.sv
test/tb.sv
